// ===== sv/jafp_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and cosine tables of the joint angle block
package jafp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int TIME_W          = 32;
  localparam int KIND_W          = 2;
  localparam int ANGLE_W         = 8;
  localparam int IN_DATA_W       = 80;
  localparam int OUT_DATA_W      = 8;

  localparam int SCALED_W        = 14;
  localparam int MUL_W           = 32;
  localparam int PROD_W          = 64;
  localparam int NORM_W          = 30;
  localparam int DOT_W           = 32;
  localparam int SQ_W            = 60;
  localparam int TSQ_W           = 61;
  localparam int WIDE_W          = 128;
  localparam int LHS_SHIFT       = 60;

  localparam int CNT_W           = 4;
  localparam int BIT_W           = 3;
  localparam int DOT_OPS         = 9;
  localparam int NORM_OPS        = 2;
  localparam int WIDE_OPS        = 4;

  localparam int HALF_TURN       = 180;
  localparam int QUARTER_TURN    = 90;
  localparam int Q_SHIFT         = 30;
  localparam int TAYLOR_TERMS    = 8;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint COS_BIAS         = 64'sd16;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240};

  typedef enum logic [KIND_W-1:0] {
    JK_ELBOW    = 2'd0,
    JK_SHOULDER = 2'd1,
    JK_HIP      = 2'd2,
    JK_OTHER    = 2'd3
  } joint_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DOT,
    ST_NORM,
    ST_LOOK,
    ST_MUL,
    ST_CMP,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic               idle;
    logic               done;
    logic [ANGLE_W-1:0] angle;
    logic               degen;
  } seq_stat_t;

  typedef logic [TSQ_W-1:0] tsq_tab_t [HALF_TURN+1];
  typedef logic [HALF_TURN:0] tneg_tab_t;

  // cosine of d degrees in q30 plus bias, truncated taylor series
  function automatic longint cos_q30(input int unsigned d);
    int unsigned       ad;
    longint unsigned   a;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   pos;
    longint unsigned   neg;
    longint            r;
    ad   = (d <= QUARTER_TURN) ? d : HALF_TURN - d;
    a    = 64'(ad);
    x    = (a * PI_Q30) / HALF_TURN;
    x2   = (x * x) >> Q_SHIFT;
    term = ONE_Q30;
    pos  = ONE_Q30;
    neg  = 64'd0;
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      term = ((term * x2) >> Q_SHIFT) / TAYLOR_DIV[k];
      if (k[0] == 1'b0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    r = longint'(pos) - longint'(neg);
    return ((d <= QUARTER_TURN) ? r : -r) + COS_BIAS;
  endfunction

  function automatic tsq_tab_t build_tsq();
    tsq_tab_t        tab;
    longint          t;
    longint unsigned m;
    for (int d = 0; d <= HALF_TURN; d++) begin
      t      = cos_q30(d);
      m      = (t < 0) ? 64'(-t) : 64'(t);
      tab[d] = TSQ_W'(m * m);
    end
    return tab;
  endfunction

  function automatic tneg_tab_t build_tneg();
    tneg_tab_t tab;
    for (int d = 0; d <= HALF_TURN; d++) begin
      tab[d] = (cos_q30(d) < 0);
    end
    return tab;
  endfunction

  // squared cosine magnitude and cosine sign for 0..180 degrees
  localparam tsq_tab_t  TSQ_TAB  = build_tsq();
  localparam tneg_tab_t TNEG_TAB = build_tneg();

endpackage

// ===== sv/joint_angle_from_three_points.sv =====
`timescale 1ns / 1ps
// top level: point store, stream ports and result register of the shoulder angle block
//
//  channel   direction  payload                                            accept
//  s_axis    in         tdata: x, y, z, sample_time; tuser: joint_kind     tvalid & tready
//  m_axis    out        tdata: angle_deg; tuser: degenerate                tvalid & tready
//
//  a point that stays in the current group, or the first point, does not stall the input
//  a point with a new timestamp keeps the input stalled through the prescale step, the
//  dot product and norms, the product of the norms and the square of the dot product, then 8
//  search steps, each a table lookup, followed where the wide product is needed by its
//  partial products on the shared 32x32 multiplier and a compare, then the result hand-over
//  a zero-length vector skips to the hand-over; the result register lets the next point in
//  while a result waits, and a further result waits until the register is free
//  reset clears the group time, the started flag and the stored points to zero
module joint_angle_from_three_points #(
  parameter int COORD_WIDTH = jafp_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z, [79:48] sample_time
  input  logic [jafp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] joint_kind
  input  logic [jafp_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] angle_deg
  output logic [jafp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] degenerate
  output logic [0:0]                        m_axis_tuser
);

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int FW     = jafp_pkg::FIELD_W;

  logic signed [COORD_WIDTH-1:0] elbow_q    [3];
  logic signed [COORD_WIDTH-1:0] shoulder_q [3];
  logic signed [COORD_WIDTH-1:0] hip_q      [3];
  logic signed [COORD_WIDTH-1:0] pt         [3];
  logic signed [DIFF_W-1:0]      u_q        [3];
  logic signed [DIFF_W-1:0]      v_q        [3];

  logic                          started_q;
  logic [jafp_pkg::TIME_W-1:0]   group_time_q;
  logic [jafp_pkg::TIME_W-1:0]   sample_time;
  logic                          accept;
  logic                          start;
  logic                          ack;

  logic                          out_valid_q;
  logic [jafp_pkg::ANGLE_W-1:0]  out_angle_q;
  logic                          out_degen_q;

  jafp_pkg::seq_stat_t           stat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = COORD_WIDTH'(32'(s_axis_tdata[FW*i +: FW]));
    end
  end

  assign sample_time   = s_axis_tdata[3*FW +: jafp_pkg::TIME_W];
  assign s_axis_tready = stat.idle;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // a new timestamp closes the group held so far
  assign start         = accept && started_q && (sample_time != group_time_q);
  assign ack           = stat.done && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      group_time_q <= '0;
      for (int i = 0; i < 3; i++) begin
        elbow_q[i]    <= '0;
        shoulder_q[i] <= '0;
        hip_q[i]      <= '0;
      end
    end else if (accept) begin
      started_q    <= 1'b1;
      group_time_q <= sample_time;
      case (jafp_pkg::joint_kind_e'(s_axis_tuser))
        jafp_pkg::JK_ELBOW:    elbow_q    <= pt;
        jafp_pkg::JK_SHOULDER: shoulder_q <= pt;
        jafp_pkg::JK_HIP:      hip_q      <= pt;
        default: begin
          // other points only count for their timestamp
        end
      endcase
    end
  end

  // difference vectors taken from the points before this request is stored
  always_ff @(posedge clk_i) begin
    if (start) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= DIFF_W'(elbow_q[i]) - DIFF_W'(shoulder_q[i]);
        v_q[i] <= DIFF_W'(hip_q[i]) - DIFF_W'(shoulder_q[i]);
      end
    end
  end

  jafp_seq #(.COORD_WIDTH(COORD_WIDTH)) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .u_i     (u_q),
    .v_i     (v_q),
    .ack_i   (ack),
    .stat_o  (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ack) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_angle_q <= stat.angle;
      out_degen_q <= stat.degen;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_angle_q;
  assign m_axis_tuser  = out_degen_q;

endmodule

// ===== sv/jafp_scale.sv =====
`timescale 1ns / 1ps
// prescaler: magnitudes, signs and a common shift of one difference vector
module jafp_scale #(
  parameter int COORD_WIDTH = jafp_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH:0]       vec_i [3],
  output logic [jafp_pkg::SCALED_W-1:0]     mag_o [3],
  output logic [2:0]                        neg_o,
  output logic                              zero_o
);

  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int MAG_W   = COORD_WIDTH;
  localparam int SHIFT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]   mag_full [3];
  logic [MAG_W-1:0]   mag_or;
  logic [SHIFT_W-1:0] blen;
  logic [SHIFT_W-1:0] shamt;

  always_comb begin
    mag_or = '0;
    for (int i = 0; i < 3; i++) begin
      neg_o[i]    = vec_i[i][DIFF_W-1];
      mag_full[i] = MAG_W'(vec_i[i][DIFF_W-1] ? -vec_i[i] : vec_i[i]);
      mag_or      = mag_or | mag_full[i];
    end
    // bit length of the or equals that of the largest magnitude
    blen = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mag_or[b]) begin
        blen = SHIFT_W'(b + 1);
      end
    end
    shamt = (blen > SHIFT_W'(jafp_pkg::SCALED_W)) ?
            blen - SHIFT_W'(jafp_pkg::SCALED_W) : '0;
    for (int i = 0; i < 3; i++) begin
      mag_o[i] = jafp_pkg::SCALED_W'(mag_full[i] >> shamt);
    end
    zero_o = (mag_or == '0);
  end

endmodule

// ===== sv/jafp_mul.sv =====
`timescale 1ns / 1ps
// shared 32 x 32 unsigned multiplier with registered product
module jafp_mul (
  input  logic                          clk_i,
  input  logic [jafp_pkg::MUL_W-1:0]    a_i,
  input  logic [jafp_pkg::MUL_W-1:0]    b_i,
  output logic [jafp_pkg::PROD_W-1:0]   prod_o
);

  logic [jafp_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= jafp_pkg::PROD_W'(a_i) * jafp_pkg::PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/jafp_seq.sv =====
`timescale 1ns / 1ps
// sequencer: dot product, norms and binary search of the angle on the shared multiplier
module jafp_seq #(
  parameter int COORD_WIDTH = jafp_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [COORD_WIDTH:0] u_i [3],
  input  logic signed [COORD_WIDTH:0] v_i [3],
  input  logic                       ack_i,
  output jafp_pkg::seq_stat_t        stat_o
);

  localparam int SCW = jafp_pkg::SCALED_W;
  localparam int CW  = jafp_pkg::CNT_W;
  localparam int AW  = jafp_pkg::ANGLE_W;
  localparam int BW  = jafp_pkg::BIT_W;
  localparam int MW  = jafp_pkg::MUL_W;
  localparam int WW  = jafp_pkg::WIDE_W;

  jafp_pkg::seq_state_e state_q, state_d;

  logic [CW-1:0]  cnt_q, cnt_d;
  logic [BW-1:0]  bit_q, bit_d;
  logic [AW-1:0]  ang_q, ang_d;
  logic           degen_q, degen_d;

  logic [SCW-1:0] su_q [3];
  logic [SCW-1:0] su_d [3];
  logic [SCW-1:0] sv_q [3];
  logic [SCW-1:0] sv_d [3];
  logic [2:0]     su_neg_q, su_neg_d, sv_neg_q, sv_neg_d;

  logic signed [jafp_pkg::DOT_W-1:0] dot_q, dot_d;
  logic [jafp_pkg::NORM_W-1:0]       n1_q, n1_d, n2_q, n2_d;
  logic [jafp_pkg::SQ_W-1:0]         p_q, p_d, d2_q, d2_d;
  logic [jafp_pkg::TSQ_W-1:0]        tsq_q, tsq_d;
  logic [WW-1:0]                     acc_q, acc_d;

  logic [SCW-1:0] su_c [3];
  logic [SCW-1:0] sv_c [3];
  logic [2:0]     su_neg_c, sv_neg_c;
  logic           u_zero, v_zero;

  logic [MW-1:0]                mul_a, mul_b;
  logic [jafp_pkg::PROD_W-1:0]  prod;

  logic [CW-1:0]                acc_idx;
  logic [jafp_pkg::DOT_W-1:0]   dot_abs;
  logic                         dot_pos;
  logic                         term_neg;
  logic signed [jafp_pkg::DOT_W-1:0] dot_term;
  logic [AW-1:0]                cand;
  logic                         cand_ok;
  logic [AW-1:0]                tab_idx;
  logic                         tneg_c;
  logic                         look_mul;
  logic                         look_pass;
  logic [WW-1:0]                lhs;
  logic                         cmp_pass;
  logic [6:0]                   pp_shift;

  jafp_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale_u (
    .vec_i  (u_i),
    .mag_o  (su_c),
    .neg_o  (su_neg_c),
    .zero_o (u_zero)
  );

  jafp_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale_v (
    .vec_i  (v_i),
    .mag_o  (sv_c),
    .neg_o  (sv_neg_c),
    .zero_o (v_zero)
  );

  jafp_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // search step decision
  always_comb begin
    acc_idx   = cnt_q - CW'(1);
    dot_pos   = (dot_q > 0);
    dot_abs   = dot_q[jafp_pkg::DOT_W-1] ? jafp_pkg::DOT_W'(-dot_q)
                                         : jafp_pkg::DOT_W'(dot_q);
    cand      = ang_q | (AW'(1) << bit_q);
    cand_ok   = (cand <= AW'(jafp_pkg::HALF_TURN));
    tab_idx   = cand_ok ? cand : '0;
    tneg_c    = jafp_pkg::TNEG_TAB[tab_idx];
    // opposite signs decide at once, like signs need the wide compare
    look_mul  = cand_ok && (dot_pos ^ tneg_c);
    look_pass = cand_ok && !dot_pos && !tneg_c;
    lhs       = WW'(d2_q) << jafp_pkg::LHS_SHIFT;
    cmp_pass  = dot_pos ? (lhs <= acc_q) : (acc_q <= lhs);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jafp_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = jafp_pkg::ST_SCALE;
        end
      end
      jafp_pkg::ST_SCALE: begin
        state_d = (u_zero || v_zero) ? jafp_pkg::ST_EMIT : jafp_pkg::ST_DOT;
      end
      jafp_pkg::ST_DOT: begin
        if (cnt_q == CW'(jafp_pkg::DOT_OPS)) begin
          state_d = jafp_pkg::ST_NORM;
        end
      end
      jafp_pkg::ST_NORM: begin
        if (cnt_q == CW'(jafp_pkg::NORM_OPS)) begin
          state_d = jafp_pkg::ST_LOOK;
        end
      end
      jafp_pkg::ST_LOOK: begin
        if (look_mul) begin
          state_d = jafp_pkg::ST_MUL;
        end else if (bit_q == '0) begin
          state_d = jafp_pkg::ST_EMIT;
        end
      end
      jafp_pkg::ST_MUL: begin
        if (cnt_q == CW'(jafp_pkg::WIDE_OPS)) begin
          state_d = jafp_pkg::ST_CMP;
        end
      end
      jafp_pkg::ST_CMP: begin
        state_d = (bit_q == '0) ? jafp_pkg::ST_EMIT : jafp_pkg::ST_LOOK;
      end
      jafp_pkg::ST_EMIT: begin
        if (ack_i) begin
          state_d = jafp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = jafp_pkg::ST_IDLE;
      end
    endcase
  end

  // multiplier operands and status
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      jafp_pkg::ST_DOT: begin
        case (cnt_q)
          4'd0: begin mul_a = MW'(su_q[0]); mul_b = MW'(sv_q[0]); end
          4'd1: begin mul_a = MW'(su_q[1]); mul_b = MW'(sv_q[1]); end
          4'd2: begin mul_a = MW'(su_q[2]); mul_b = MW'(sv_q[2]); end
          4'd3: begin mul_a = MW'(su_q[0]); mul_b = MW'(su_q[0]); end
          4'd4: begin mul_a = MW'(su_q[1]); mul_b = MW'(su_q[1]); end
          4'd5: begin mul_a = MW'(su_q[2]); mul_b = MW'(su_q[2]); end
          4'd6: begin mul_a = MW'(sv_q[0]); mul_b = MW'(sv_q[0]); end
          4'd7: begin mul_a = MW'(sv_q[1]); mul_b = MW'(sv_q[1]); end
          4'd8: begin mul_a = MW'(sv_q[2]); mul_b = MW'(sv_q[2]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      jafp_pkg::ST_NORM: begin
        case (cnt_q)
          4'd0: begin mul_a = MW'(n1_q); mul_b = MW'(n2_q); end
          4'd1: begin mul_a = MW'(dot_abs); mul_b = MW'(dot_abs); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      jafp_pkg::ST_MUL: begin
        // four partial products of the 61 x 60 bit compare operand
        case (cnt_q)
          4'd0: begin mul_a = tsq_q[MW-1:0]; mul_b = p_q[MW-1:0]; end
          4'd1: begin
            mul_a = tsq_q[MW-1:0];
            mul_b = MW'(p_q[jafp_pkg::SQ_W-1:MW]);
          end
          4'd2: begin
            mul_a = MW'(tsq_q[jafp_pkg::TSQ_W-1:MW]);
            mul_b = p_q[MW-1:0];
          end
          4'd3: begin
            mul_a = MW'(tsq_q[jafp_pkg::TSQ_W-1:MW]);
            mul_b = MW'(p_q[jafp_pkg::SQ_W-1:MW]);
          end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    stat_o.idle  = (state_q == jafp_pkg::ST_IDLE);
    stat_o.done  = (state_q == jafp_pkg::ST_EMIT);
    stat_o.angle = ang_q;
    stat_o.degen = degen_q;
  end

  // datapath next values
  always_comb begin
    cnt_d    = cnt_q;
    bit_d    = bit_q;
    ang_d    = ang_q;
    degen_d  = degen_q;
    su_d     = su_q;
    sv_d     = sv_q;
    su_neg_d = su_neg_q;
    sv_neg_d = sv_neg_q;
    dot_d    = dot_q;
    n1_d     = n1_q;
    n2_d     = n2_q;
    p_d      = p_q;
    d2_d     = d2_q;
    tsq_d    = tsq_q;
    acc_d    = acc_q;

    case (acc_idx)
      4'd0:    term_neg = su_neg_q[0] ^ sv_neg_q[0];
      4'd1:    term_neg = su_neg_q[1] ^ sv_neg_q[1];
      4'd2:    term_neg = su_neg_q[2] ^ sv_neg_q[2];
      default: term_neg = 1'b0;
    endcase
    dot_term = $signed({2'b00, prod[jafp_pkg::NORM_W-1:0]});

    case (acc_idx)
      4'd0:       pp_shift = 7'd0;
      4'd1, 4'd2: pp_shift = 7'd32;
      4'd3:       pp_shift = 7'd64;
      default:    pp_shift = 7'd0;
    endcase

    case (state_q)
      jafp_pkg::ST_SCALE: begin
        su_d     = su_c;
        sv_d     = sv_c;
        su_neg_d = su_neg_c;
        sv_neg_d = sv_neg_c;
        dot_d    = '0;
        n1_d     = '0;
        n2_d     = '0;
        cnt_d    = '0;
        ang_d    = '0;
        degen_d  = u_zero || v_zero;
      end
      jafp_pkg::ST_DOT: begin
        // the product of the previous operand pair lands here
        cnt_d = (cnt_q == CW'(jafp_pkg::DOT_OPS)) ? '0 : cnt_q + CW'(1);
        if (cnt_q != '0) begin
          case (acc_idx)
            4'd0, 4'd1, 4'd2: dot_d = term_neg ? dot_q - dot_term : dot_q + dot_term;
            4'd3, 4'd4, 4'd5: n1_d = n1_q + prod[jafp_pkg::NORM_W-1:0];
            4'd6, 4'd7, 4'd8: n2_d = n2_q + prod[jafp_pkg::NORM_W-1:0];
            default: begin
              dot_d = dot_q;
            end
          endcase
        end
      end
      jafp_pkg::ST_NORM: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(1)) begin
          p_d = prod[jafp_pkg::SQ_W-1:0];
        end
        if (cnt_q == CW'(jafp_pkg::NORM_OPS)) begin
          d2_d  = prod[jafp_pkg::SQ_W-1:0];
          cnt_d = '0;
          ang_d = '0;
          bit_d = BW'(AW - 1);
        end
      end
      jafp_pkg::ST_LOOK: begin
        if (look_mul) begin
          tsq_d = jafp_pkg::TSQ_TAB[tab_idx];
          acc_d = '0;
          cnt_d = '0;
        end else begin
          if (look_pass) begin
            ang_d = cand;
          end
          bit_d = bit_q - BW'(1);
        end
      end
      jafp_pkg::ST_MUL: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q != '0) begin
          acc_d = acc_q + (WW'(prod) << pp_shift);
        end
      end
      jafp_pkg::ST_CMP: begin
        if (cmp_pass) begin
          ang_d = cand;
        end
        bit_d = bit_q - BW'(1);
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jafp_pkg::ST_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q    <= ang_d;
    degen_q  <= degen_d;
    su_q     <= su_d;
    sv_q     <= sv_d;
    su_neg_q <= su_neg_d;
    sv_neg_q <= sv_neg_d;
    dot_q    <= dot_d;
    n1_q     <= n1_d;
    n2_q     <= n2_d;
    p_q      <= p_d;
    d2_q     <= d2_d;
    tsq_q    <= tsq_d;
    acc_q    <= acc_d;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the shoulder angle block: directed and random point streams
module tb_top;

  localparam longint unsigned PI_IN_Q30  = 64'd3373259426;
  localparam longint unsigned UNIT_Q30   = 64'd1073741824;
  localparam longint          COS_OFFSET = 64'sd16;
  localparam longint unsigned SCALE_MAX  = 64'd16383;
  localparam int              STALL_LIMIT   = 5000;
  localparam int              SETTLE_CYCLES = 120;

  typedef struct {
    logic signed [15:0]    x;
    logic signed [15:0]    y;
    logic signed [15:0]    z;
    jafp_pkg::joint_kind_e kind;
    logic [31:0]           stamp;
  } point_t;

  typedef struct packed {
    logic [7:0] angle;
    logic       degen;
  } angle_res_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [jafp_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic [jafp_pkg::KIND_W-1:0]       s_axis_tuser = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [jafp_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic [0:0]                        m_axis_tuser;

  // predictor state
  logic [31:0] group_stamp;
  logic        group_open;
  longint      joint_pos [3][3];
  longint      cos_tab [0:180];
  angle_res_t  angle_q [$];

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          fail_count = 0;
  int unsigned points_sent = 0;
  logic [31:0] last_stamp = '0;

  joint_angle_from_three_points DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // cosine in q30 with bias, folded about the right angle
  function automatic longint cosine_q30(int unsigned deg);
    longint unsigned rad;
    longint unsigned rad_sq;
    longint unsigned term;
    longint unsigned plus;
    longint unsigned minus;
    longint          sum;
    rad    = (deg <= 90) ? deg : 180 - deg;
    rad    = (rad * PI_IN_Q30) / 180;
    rad_sq = (rad * rad) >> 30;
    term   = UNIT_Q30;
    plus   = UNIT_Q30;
    minus  = 64'd0;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * rad_sq) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        minus = minus + term;
      end else begin
        plus = plus + term;
      end
    end
    sum = $signed(plus) - $signed(minus);
    return ((deg <= 90) ? sum : -sum) + COS_OFFSET;
  endfunction

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? $unsigned(-v) : $unsigned(v);
  endfunction

  function automatic int unsigned fit_shift(longint a, longint b, longint c);
    longint unsigned top;
    int unsigned     sh;
    top = mag64(a);
    if (mag64(b) > top) top = mag64(b);
    if (mag64(c) > top) top = mag64(c);
    sh = 0;
    while ((top >> sh) > SCALE_MAX) sh++;
    return sh;
  endfunction

  function automatic longint shrink(longint c, int unsigned sh);
    longint q;
    q = $signed(mag64(c) >> sh);
    return (c < 0) ? -q : q;
  endfunction

  // largest whole degree for which every test up to it passes
  function automatic angle_res_t shoulder_angle();
    longint          u [3];
    longint          v [3];
    longint          dot;
    longint          n1;
    longint          n2;
    longint          t;
    longint unsigned prod;
    longint unsigned dsq;
    longint unsigned tsq;
    int unsigned     shu;
    int unsigned     shv;
    logic [127:0]    lhs;
    logic [127:0]    rhs;
    logic            ok;
    angle_res_t      res;
    for (int i = 0; i < 3; i++) begin
      u[i] = joint_pos[jafp_pkg::JK_ELBOW][i] - joint_pos[jafp_pkg::JK_SHOULDER][i];
      v[i] = joint_pos[jafp_pkg::JK_HIP][i] - joint_pos[jafp_pkg::JK_SHOULDER][i];
    end
    res.angle = 8'd0;
    res.degen = (u[0] == 0 && u[1] == 0 && u[2] == 0) ||
                (v[0] == 0 && v[1] == 0 && v[2] == 0);
    if (res.degen) return res;
    shu = fit_shift(u[0], u[1], u[2]);
    shv = fit_shift(v[0], v[1], v[2]);
    dot = 0;
    n1  = 0;
    n2  = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = shrink(u[i], shu);
      v[i] = shrink(v[i], shv);
      dot  = dot + u[i] * v[i];
      n1   = n1 + u[i] * u[i];
      n2   = n2 + v[i] * v[i];
    end
    prod = n1 * n2;
    dsq  = mag64(dot) * mag64(dot);
    lhs  = {4'b0, dsq, 60'b0};
    for (int d = 1; d <= 180; d++) begin
      t   = cos_tab[d];
      tsq = mag64(t) * mag64(t);
      rhs = {64'b0, tsq} * {64'b0, prod};
      if (dot <= 0 && t >= 0) ok = 1'b1;
      else if (dot > 0 && t < 0) ok = 1'b0;
      else if (dot > 0) ok = (lhs <= rhs);
      else ok = (rhs <= lhs);
      if (!ok) break;
      res.angle = 8'(d);
    end
    return res;
  endfunction

  // a new timestamp closes the group and yields its angle, then the point is stored
  function automatic void predict_point(point_t p);
    if (!group_open) begin
      group_open  = 1'b1;
      group_stamp = p.stamp;
    end else if (p.stamp != group_stamp) begin
      angle_q.insert(angle_q.size(), shoulder_angle());
      group_stamp = p.stamp;
    end
    if (p.kind != jafp_pkg::JK_OTHER) begin
      joint_pos[p.kind][0] = p.x;
      joint_pos[p.kind][1] = p.y;
      joint_pos[p.kind][2] = p.z;
    end
  endfunction

  function automatic point_t mk_point(jafp_pkg::joint_kind_e k, int x, int y, int z,
                                      logic [31:0] stamp);
    point_t p;
    p.x     = 16'(x);
    p.y     = 16'(y);
    p.z     = 16'(z);
    p.kind  = k;
    p.stamp = stamp;
    return p;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic send_point(point_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {p.stamp, p.z, p.y, p.x};
    s_axis_tuser  <= p.kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_point(p);
    points_sent++;
  endtask

  task automatic hold_until_results_in();
    s_axis_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_group();
    int          jp [3][3];
    int          order [3];
    int          pick;
    int          mode;
    int          tmp;
    int          j;
    int          dir [3];
    int          k;
    int          m;
    int          sgn;
    logic [31:0] stamp;
    pick = $urandom_range(99);
    if (pick < 60) stamp = last_stamp + 32'd1;
    else if (pick < 80) stamp = $urandom;
    else if (pick < 90) stamp = last_stamp + $urandom_range(1000, 2);
    else stamp = last_stamp - 32'd1;
    if (stamp == last_stamp) stamp = stamp + 32'd1;
    last_stamp = stamp;
    if ($urandom_range(99) < 25) begin
      // noise: a few points of any kind, joints possibly missing
      repeat ($urandom_range(4, 1))
        send_point(mk_point(jafp_pkg::joint_kind_e'($urandom_range(3)),
                            rand_coord(), rand_coord(), rand_coord(), stamp));
    end else begin
      mode = $urandom_range(99);
      k    = $urandom_range(100, 1);
      m    = $urandom_range(100, 1);
      sgn  = $urandom_range(1) ? 1 : -1;
      for (int i = 0; i < 3; i++) begin
        dir[i] = int'($urandom_range(200)) - 100;
        if (mode < 40) begin
          jp[0][i] = rand_coord();
          jp[1][i] = rand_coord();
          jp[2][i] = rand_coord();
        end else if (mode < 65) begin
          // short vectors around a far shoulder
          jp[1][i] = int'($urandom_range(64000)) - 32000;
          jp[0][i] = jp[1][i] + int'($urandom_range(128)) - 64;
          jp[2][i] = jp[1][i] + int'($urandom_range(128)) - 64;
        end else if (mode < 85) begin
          // collinear points, angle at an end of the range
          jp[1][i] = int'($urandom_range(20000)) - 10000;
          jp[0][i] = jp[1][i] + k * dir[i];
          jp[2][i] = jp[1][i] + sgn * m * dir[i];
        end else begin
          jp[0][i] = rand_coord();
          jp[1][i] = rand_coord();
          jp[2][i] = rand_coord();
        end
      end
      if (mode >= 85) begin
        for (int i = 0; i < 3; i++) begin
          if (mode < 92 || mode >= 97) jp[0][i] = jp[1][i];
          if (mode >= 92) jp[2][i] = jp[1][i];
        end
      end
      order = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
        j        = $urandom_range(i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < 3; i++)
        send_point(mk_point(jafp_pkg::joint_kind_e'(order[i]), jp[order[i]][0],
                            jp[order[i]][1], jp[order[i]][2], stamp));
      if ($urandom_range(99) < 25)
        send_point(mk_point(jafp_pkg::joint_kind_e'($urandom_range(3)),
                            rand_coord(), rand_coord(), rand_coord(), stamp));
    end
  endtask

  task automatic test_directed_cases();
    // first point only opens a group
    send_point(mk_point(jafp_pkg::JK_ELBOW, 100, 0, 0, 32'd0));
    // shoulder and hip still at reset, so degenerate
    send_point(mk_point(jafp_pkg::JK_HIP, 0, 100, 0, 32'd9));
    send_point(mk_point(jafp_pkg::JK_SHOULDER, 0, 0, 0, 32'd9));
    send_point(mk_point(jafp_pkg::JK_OTHER, -32768, 32767, -32768, 32'd9));
    // right angle, elbow kept from the first group
    send_point(mk_point(jafp_pkg::JK_ELBOW, -32768, -32768, -32768, 32'd1));
    send_point(mk_point(jafp_pkg::JK_SHOULDER, 32767, 32767, 32767, 32'd1));
    send_point(mk_point(jafp_pkg::JK_HIP, -32768, -32768, -32767, 32'd1));
    send_point(mk_point(jafp_pkg::JK_OTHER, 32767, -32768, 32767, 32'd1));
    // near-zero angle on full-scale vectors
    send_point(mk_point(jafp_pkg::JK_SHOULDER, 0, 0, 0, 32'd2));
    send_point(mk_point(jafp_pkg::JK_ELBOW, 1000, -2000, 3000, 32'd2));
    send_point(mk_point(jafp_pkg::JK_HIP, -1000, 2000, -3000, 32'd2));
    // straight angle
    send_point(mk_point(jafp_pkg::JK_ELBOW, 5, 5, 5, 32'hFFFF_FFFF));
    send_point(mk_point(jafp_pkg::JK_SHOULDER, 5, 5, 5, 32'hFFFF_FFFF));
    send_point(mk_point(jafp_pkg::JK_HIP, 1, 2, 3, 32'hFFFF_FFFF));
    // elbow on the shoulder, degenerate
    send_point(mk_point(jafp_pkg::JK_SHOULDER, -7, 0, 0, 32'h8000_0000));
    // group of just an ignored point still closes one
    send_point(mk_point(jafp_pkg::JK_OTHER, 0, 0, 0, 32'd3));
    send_point(mk_point(jafp_pkg::JK_HIP, -7, 0, 0, 32'd4));
    // hip on the shoulder, degenerate
    send_point(mk_point(jafp_pkg::JK_ELBOW, 32767, 0, 0, 32'd5));
    send_point(mk_point(jafp_pkg::JK_SHOULDER, -32768, 0, 0, 32'd5));
    send_point(mk_point(jafp_pkg::JK_HIP, -32768, 1, 0, 32'd5));
    send_point(mk_point(jafp_pkg::JK_ELBOW, 0, 32767, 0, 32'd6));
    send_point(mk_point(jafp_pkg::JK_SHOULDER, 0, -32768, -32768, 32'd6));
    send_point(mk_point(jafp_pkg::JK_HIP, 32767, -32768, -32768, 32'd6));
    send_point(mk_point(jafp_pkg::JK_OTHER, 0, 0, 0, 32'd7));
    last_stamp = 32'd7;
  endtask

  task automatic test_random_groups(int tx_pct, int rx_pct, int unsigned n_points);
    int unsigned target;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target      = points_sent + n_points;
    while (points_sent < target) send_random_group();
  endtask

  task automatic test_pause_for_results();
    send_random_group();
    send_random_group();
    hold_until_results_in();
    send_random_group();
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    angle_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual angle %0d degenerate %0b",
                 $time, m_axis_tdata, m_axis_tuser[0]);
        fail_count++;
      end else begin
        want = angle_q.pop_front();
        if (m_axis_tdata !== want.angle) begin
          $display("%0t: angle_deg expected %0d actual %0d", $time, want.angle, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, want.degen,
                   m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // ends the run if neither side moves a request for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
        quiet_cycles++;
      else
        quiet_cycles = 0;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    for (int d = 0; d <= 180; d++) cos_tab[d] = cosine_q30(d);
    group_stamp = '0;
    group_open  = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) joint_pos[i][j] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_groups(9, 64, 120);
    test_pause_for_results();
    test_random_groups(64, 9, 120);
    test_random_groups(0, 0, 120);

    hold_until_results_in();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/jafp_pkg.sv
sv/jafp_scale.sv
sv/jafp_mul.sv
sv/jafp_seq.sv
sv/joint_angle_from_three_points.sv
tb/sv/tb_top.sv
